// ----- src/clutch_gear_shift_sequencer_defines.svh -----
// ----------------------------------------------------------------------------
// Clutch gear shift sequencer assertion macros
// Shared concurrent assertion wrappers on the block clock, with or without reset.
// ----------------------------------------------------------------------------
`ifndef CLUTCH_GEAR_SHIFT_SEQUENCER_DEFINES_SVH
`define CLUTCH_GEAR_SHIFT_SEQUENCER_DEFINES_SVH

// Checked only while the block is out of reset.
`define CGSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define CGSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/cgss_pkg.sv -----
// ----------------------------------------------------------------------------
// cgss_pkg
// Types, codes and constants shared by the clutch gear shift sequencer.
// ----------------------------------------------------------------------------
package cgss_pkg;

  localparam int MAX_RES   = 6;
  localparam int RES_IDX_W = $clog2(MAX_RES + 1);
  localparam int TICK_W    = 18;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Event codes.
  localparam logic [2:0] FUNC_MAN_DOWN  = 3'd0;
  localparam logic [2:0] FUNC_MAN_UP    = 3'd1;
  localparam logic [2:0] FUNC_GEAR_DOWN = 3'd2;
  localparam logic [2:0] FUNC_GEAR_UP   = 3'd3;
  localparam logic [2:0] FUNC_RESET     = 3'd4;
  localparam logic [2:0] FUNC_TICK      = 3'd5;

  // Controller write kinds.
  localparam logic [1:0] KIND_BUTTON  = 2'd0;
  localparam logic [1:0] KIND_AXIS    = 2'd1;
  localparam logic [1:0] KIND_PUBLISH = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_CLUTCH_ENABLED = 3'd0;
  localparam logic [2:0] REG_AXIS_ID        = 3'd1;
  localparam logic [2:0] REG_PRESS_VALUE    = 3'd2;
  localparam logic [2:0] REG_RELEASE_VALUE  = 3'd3;
  localparam logic [2:0] REG_FRAME_MODE     = 3'd4;
  localparam logic [2:0] REG_PRESS_WAIT     = 3'd5;
  localparam logic [2:0] REG_RELEASE_WAIT   = 3'd6;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] gear_code;
  } cgss_in_t;

  typedef struct packed {
    logic [1:0]  write_kind;
    logic [15:0] target;
    logic [15:0] write_value;
    logic        last;
  } cgss_out_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] target;
    logic [15:0] value;
  } cgss_wr_t;

  typedef struct packed {
    cgss_wr_t [MAX_RES-1:0] items;
    logic [RES_IDX_W-1:0]   cnt;
  } cgss_res_t;

  typedef struct packed {
    logic        clutch_enabled;
    logic [7:0]  axis_id;
    logic [15:0] press_value;
    logic [15:0] release_value;
    logic        frame_mode;
    logic [15:0] press_wait;
    logic [15:0] release_wait;
  } cgss_cfg_t;

  typedef struct packed {
    logic [15:0]       active_gear;
    logic [15:0]       queued_gear;
    logic              gear_held;
    logic              manual_demand;
    logic              auto_demand;
    logic              axis_engaged;
    logic              sequence_running;
    logic [TICK_W-1:0] tick_index;
    logic              seq_frame;
    logic [15:0]       seq_press;
    logic [15:0]       seq_release;
  } cgss_state_t;

  localparam cgss_cfg_t CFG_RESET = '{
    clutch_enabled: 1'b1,
    axis_id:        8'd0,
    press_value:    16'hFFFF,
    release_value:  16'd0,
    frame_mode:     1'b0,
    press_wait:     16'd50,
    release_wait:   16'd50
  };

endpackage

// ----- src/cgss_step.sv -----
// ----------------------------------------------------------------------------
// cgss_step
// Next-state and write-list logic for one event, all in a single pass.
// ----------------------------------------------------------------------------
module cgss_step (
  input  cgss_pkg::cgss_state_t st_i,
  input  cgss_pkg::cgss_cfg_t   cfg_i,
  input  cgss_pkg::cgss_in_t    item_i,
  output cgss_pkg::cgss_state_t st_nxt,
  output cgss_pkg::cgss_res_t   res_o
);
  import cgss_pkg::*;

  typedef struct packed {
    cgss_state_t st;
    cgss_res_t   res;
  } cgss_work_t;

  function automatic cgss_work_t emit(cgss_work_t w, logic [1:0] kind,
                                      logic [15:0] tgt, logic [15:0] val);
    cgss_work_t r;
    r = w;
    if (r.res.cnt < RES_IDX_W'(MAX_RES)) begin
      r.res.items[r.res.cnt].kind   = kind;
      r.res.items[r.res.cnt].target = tgt;
      r.res.items[r.res.cnt].value  = val;
      r.res.cnt = r.res.cnt + 1'b1;
    end
    return r;
  endfunction

  // The axis follows manual OR automatic demand; writes only when enabled.
  function automatic cgss_work_t sync_axis(cgss_work_t w, cgss_cfg_t c);
    cgss_work_t r;
    logic       want;
    r = w;
    want = r.st.manual_demand | r.st.auto_demand;
    if (want != r.st.axis_engaged) begin
      r.st.axis_engaged = want;
      if (c.clutch_enabled) begin
        r = emit(r, KIND_AXIS, {8'h00, c.axis_id},
                 want ? c.press_value : c.release_value);
        r = emit(r, KIND_PUBLISH, 16'd0, 16'd0);
      end
    end
    return r;
  endfunction

  // Mode and both waits are latched here; axis values stay live.
  function automatic cgss_work_t start_seq(cgss_work_t w, cgss_cfg_t c);
    cgss_work_t r;
    r = w;
    r.st.sequence_running = 1'b1;
    r.st.tick_index       = '0;
    r.st.seq_frame        = c.frame_mode;
    r.st.seq_press        = c.press_wait;
    r.st.seq_release      = c.release_wait;
    if (!c.frame_mode) begin
      r.st.auto_demand = 1'b1;
      r = sync_axis(r, c);
    end
    return r;
  endfunction

  cgss_work_t        w;
  logic              want_gear;
  logic              want_clutch;
  logic              publish;
  logic [16:0]       wait_sum;
  logic [15:0]       code;

  always_comb begin
    w           = '0;
    w.st        = st_i;
    want_gear   = 1'b0;
    want_clutch = 1'b0;
    publish     = 1'b0;
    code        = item_i.gear_code;
    wait_sum    = {1'b0, st_i.seq_press} + {1'b0, st_i.seq_release};
    case (item_i.func)
      FUNC_MAN_DOWN: begin
        if (!w.st.manual_demand) begin
          w.st.manual_demand = 1'b1;
          w = sync_axis(w, cfg_i);
        end
      end
      FUNC_MAN_UP: begin
        if (w.st.manual_demand) begin
          w.st.manual_demand = 1'b0;
          w = sync_axis(w, cfg_i);
        end
      end
      FUNC_GEAR_DOWN: begin
        if (code == w.st.active_gear || code == w.st.queued_gear) begin
          w = w;
        end else if (w.st.active_gear != '0) begin
          w.st.queued_gear = code;
        end else begin
          w.st.active_gear = code;
          w = start_seq(w, cfg_i);
        end
      end
      FUNC_GEAR_UP: begin
        if (code == w.st.queued_gear) begin
          w.st.queued_gear = '0;
        end else if (code == w.st.active_gear) begin
          if (w.st.gear_held) begin
            w = emit(w, KIND_BUTTON, code, 16'd0);
            w = emit(w, KIND_PUBLISH, 16'd0, 16'd0);
          end
          w.st.auto_demand = 1'b0;
          w = sync_axis(w, cfg_i);
          w.st.active_gear      = '0;
          w.st.gear_held        = 1'b0;
          w.st.sequence_running = 1'b0;
          if (w.st.queued_gear != '0) begin
            w.st.active_gear = w.st.queued_gear;
            w.st.queued_gear = '0;
            w = start_seq(w, cfg_i);
          end
        end
      end
      FUNC_RESET: begin
        w.st.queued_gear = '0;
        if (w.st.active_gear != '0) begin
          if (w.st.gear_held) begin
            w = emit(w, KIND_BUTTON, w.st.active_gear, 16'd0);
            publish = 1'b1;
          end
          w.st.active_gear      = '0;
          w.st.gear_held        = 1'b0;
          w.st.sequence_running = 1'b0;
        end
        w.st.manual_demand = 1'b0;
        w.st.auto_demand   = 1'b0;
        if (w.st.axis_engaged) begin
          w.st.axis_engaged = 1'b0;
          if (cfg_i.clutch_enabled) begin
            w = emit(w, KIND_AXIS, {8'h00, cfg_i.axis_id}, cfg_i.release_value);
            publish = 1'b1;
          end
        end
        if (publish) begin
          w = emit(w, KIND_PUBLISH, 16'd0, 16'd0);
        end
      end
      FUNC_TICK: begin
        if (w.st.sequence_running) begin
          if (w.st.seq_frame) begin
            // Frame mode: the counter wraps, and every tick publishes.
            w.st.tick_index = w.st.tick_index + 1'b1;
            want_gear   = w.st.tick_index > TICK_W'(w.st.seq_press);
            want_clutch = w.st.tick_index <= TICK_W'(wait_sum);
            if (want_gear && !w.st.gear_held) begin
              w = emit(w, KIND_BUTTON, w.st.active_gear, 16'd1);
              w.st.gear_held = 1'b1;
            end
            w.st.auto_demand = want_clutch;
            w = sync_axis(w, cfg_i);
            w = emit(w, KIND_PUBLISH, 16'd0, 16'd0);
            if (!want_clutch) begin
              w.st.sequence_running = 1'b0;
            end
          end else begin
            // Millisecond mode: the counter saturates and restarts at the press.
            if (w.st.tick_index != TICK_MAX) begin
              w.st.tick_index = w.st.tick_index + 1'b1;
            end
            if (!w.st.gear_held && w.st.tick_index >= TICK_W'(w.st.seq_press)) begin
              w = emit(w, KIND_BUTTON, w.st.active_gear, 16'd1);
              w = emit(w, KIND_PUBLISH, 16'd0, 16'd0);
              w.st.gear_held  = 1'b1;
              w.st.tick_index = '0;
            end
            if (w.st.gear_held && w.st.tick_index >= TICK_W'(w.st.seq_release)) begin
              w.st.auto_demand = 1'b0;
              w = sync_axis(w, cfg_i);
              w.st.sequence_running = 1'b0;
            end
          end
        end
      end
      default: begin
        w = w;
      end
    endcase
    st_nxt = w.st;
    res_o  = w.res;
  end

endmodule

// ----- src/clutch_gear_shift_sequencer.sv -----
// An accepted event is held in the input register, and its writes are registered
// into the write-list buffer before the first is offered on out_.
// Throughput: one event per cycle while events cause no writes; otherwise the
// next event waits until the last of N writes (N up to 6) leaves the single write port.
// Reset: synchronous, active low; clears all sequencing state and returns the
// registers to their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
// clutch_gear_shift_sequencer
// Event-driven clutch and gear shift sequencer with an APB register port.
// ----------------------------------------------------------------------------
`include "clutch_gear_shift_sequencer_defines.svh"

module clutch_gear_shift_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cgss_pkg::cgss_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cgss_pkg::cgss_out_t                 out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [cgss_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [cgss_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [cgss_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import cgss_pkg::*;

  cgss_cfg_t              cfg_r;
  cgss_state_t            st_r;
  cgss_state_t            st_nxt;
  cgss_res_t              res_nxt;
  logic                   inq_valid_r;
  cgss_in_t               inq_data_r;
  cgss_wr_t [MAX_RES-1:0] buf_r;
  logic [RES_IDX_W-1:0]   buf_cnt_r;
  logic [RES_IDX_W-1:0]   rd_idx_r;
  logic                   out_fire;
  logic                   in_fire;
  logic                   rd_last;
  logic                   buf_free;
  logic                   go;
  logic                   cfg_wr;
  logic [2:0]             cfg_idx;
  cgss_wr_t               rd_entry;

  cgss_step u_step (
    .st_i   (st_r),
    .cfg_i  (cfg_r),
    .item_i (inq_data_r),
    .st_nxt (st_nxt),
    .res_o  (res_nxt)
  );

  // The write list drains one beat per cycle while out_stall is low; the next event
  // is processed in the same cycle that the final beat leaves.
  assign out_valid = rd_idx_r != buf_cnt_r;
  assign out_fire  = out_valid && !out_stall;
  assign rd_last   = RES_IDX_W'(rd_idx_r + 1'b1) == buf_cnt_r;
  assign buf_free  = !out_valid || (out_fire && rd_last);
  assign go        = inq_valid_r && buf_free;
  assign in_stall  = inq_valid_r && !buf_free;
  assign in_fire   = in_valid && !in_stall;

  assign rd_entry             = buf_r[rd_idx_r];
  assign out_data.write_kind  = rd_entry.kind;
  assign out_data.target      = rd_entry.target;
  assign out_data.write_value = rd_entry.value;
  assign out_data.last        = rd_last;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_idx)
      REG_CLUTCH_ENABLED: cfg_prdata = CFG_DATA_W'(cfg_r.clutch_enabled);
      REG_AXIS_ID:        cfg_prdata = CFG_DATA_W'(cfg_r.axis_id);
      REG_PRESS_VALUE:    cfg_prdata = CFG_DATA_W'(cfg_r.press_value);
      REG_RELEASE_VALUE:  cfg_prdata = CFG_DATA_W'(cfg_r.release_value);
      REG_FRAME_MODE:     cfg_prdata = CFG_DATA_W'(cfg_r.frame_mode);
      REG_PRESS_WAIT:     cfg_prdata = CFG_DATA_W'(cfg_r.press_wait);
      REG_RELEASE_WAIT:   cfg_prdata = CFG_DATA_W'(cfg_r.release_wait);
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      st_r        <= '0;
      inq_valid_r <= 1'b0;
      buf_cnt_r   <= '0;
      rd_idx_r    <= '0;
    end else begin
      if (in_fire) begin
        inq_valid_r <= 1'b1;
      end else if (go) begin
        inq_valid_r <= 1'b0;
      end
      if (go) begin
        st_r      <= st_nxt;
        buf_cnt_r <= res_nxt.cnt;
        rd_idx_r  <= '0;
      end else if (out_fire) begin
        rd_idx_r <= RES_IDX_W'(rd_idx_r + 1'b1);
      end
      if (cfg_wr) begin
        case (cfg_idx)
          REG_CLUTCH_ENABLED: cfg_r.clutch_enabled <= cfg_pwdata[0];
          REG_AXIS_ID:        cfg_r.axis_id        <= cfg_pwdata[7:0];
          REG_PRESS_VALUE:    cfg_r.press_value    <= cfg_pwdata[15:0];
          REG_RELEASE_VALUE:  cfg_r.release_value  <= cfg_pwdata[15:0];
          REG_FRAME_MODE:     cfg_r.frame_mode     <= cfg_pwdata[0];
          REG_PRESS_WAIT:     cfg_r.press_wait     <= cfg_pwdata[15:0];
          REG_RELEASE_WAIT:   cfg_r.release_wait   <= cfg_pwdata[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      inq_data_r <= in_data;
    end
    if (go) begin
      buf_r <= res_nxt.items;
    end
  end

  `CGSS_ASSERT(a_buf_bounds, (rd_idx_r <= buf_cnt_r) && (buf_cnt_r <= RES_IDX_W'(MAX_RES)), "write list index out of range")
  `CGSS_ASSERT(a_drain_empties, (out_fire && rd_last && !go) |=> !out_valid, "write list not empty after final beat")
  `CGSS_ASSERT(a_held_needs_gear, st_r.gear_held |-> (st_r.active_gear != '0), "gear held with no active gear")
  `CGSS_ASSERT(a_queue_needs_active, (st_r.queued_gear != '0) |-> ((st_r.active_gear != '0) && (st_r.active_gear != st_r.queued_gear)), "queued gear without a distinct active gear")
  `CGSS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_valid && !in_stall), "block not idle after reset")

endmodule
